@@ rtl/rrss_pkg.sv @@
// Shared types and constants for the round robin slot shuffle.
`default_nettype none
package rrss_pkg;
	localparam int MAX_PRODUCERS_DEF = 64;
	localparam logic [63:0] SHUF_MUL = 64'd2685821657736338717;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_QUERY  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] producer_id;
		logic [31:0] block_number;
		logic [31:0] block_time;
		logic [63:0] absolute_slot;
		logic [31:0] slot_offset;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] scheduled_id;
		logic [5:0]  position;
		logic        last;
		logic        empty_error;
	} out_item_t;

	// request to the shared modulo unit, and its answer
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [6:0]  divisor;
	} mod_req_t;

	typedef struct packed {
		logic       done;
		logic [6:0] rem;
	} mod_rsp_t;
endpackage
`default_nettype wire

@@ rtl/rrss_ram.sv @@
// Generic single write port, single registered read port RAM.
`default_nettype none
module rrss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/rrss_mod.sv @@
// Bit-serial restoring remainder of a 64-bit value by a 7-bit divisor.
`default_nettype none
module rrss_mod
	import rrss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mod_req_t req,
	output mod_rsp_t      rsp
);
	logic [63:0] dvd_q;
	logic [6:0]  dvs_q;
	logic [7:0]  rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  trial;

	always_comb begin
		trial = {rem_q[6:0], dvd_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[62:0], 1'b0};
				if (trial >= {1'b0, dvs_q}) rem_q <= trial - {1'b0, dvs_q};
				else rem_q <= trial;
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{done_q, rem_q[6:0]};
endmodule
`default_nettype wire

@@ rtl/round_robin_slot_shuffle.sv @@
// Top level: producer list, shuffled schedule and slot query.
`default_nettype none
// Appends and clears complete without leaving the idle state. A slot query on
// an empty schedule answers without the remainder unit; any other query first
// reduces the slot modulo the schedule length. A block update first checks the
// block number modulo the producer count; when the remainder is zero it
// shuffles: it copies the producer list, then draws and swaps once per producer,
// then emits the schedule. The bit-serial remainder unit dominates each draw;
// the 64x64 multiply of the xorshift step runs as three 32x32 partial products
// on one multiplier. One item is worked on at a time and the input is stalled
// until it is done; a finished result waits in the output register and only
// holds back the next item once that item has a result of its own.
module round_robin_slot_shuffle
	import rrss_pkg::*;
#(
	parameter int MAX_PRODUCERS = MAX_PRODUCERS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_item_t     out_data
);
	localparam int AW = $clog2(MAX_PRODUCERS);
	localparam logic [6:0] MAXC = 7'(MAX_PRODUCERS);

	typedef enum logic [4:0] {
		S_IDLE, S_BMOD, S_CPRD, S_CPWR, S_SEED, S_XS, S_M0, S_M1, S_M2, S_M3,
		S_JMOD, S_RDI, S_RDJ, S_WRI, S_WRJ, S_ERD, S_EWAIT, S_EOUT,
		S_QMOD, S_QRD, S_QWAIT, S_QOUT
	} state_t;

	state_t      state_q;
	in_item_t    item_q;
	logic [6:0]  acount_q, scount_q, n_q;
	logic [6:0]  i_q;
	logic [5:0]  j_q;
	logic [63:0] k_q, p_q;
	logic [31:0] ti_q;
	mod_req_t    mreq;
	mod_rsp_t    mrsp;

	logic          a_we, s_we;
	logic [AW-1:0] a_waddr, a_raddr, s_waddr, s_raddr;
	logic [31:0]   a_wdata, s_wdata, a_rdata, s_rdata;
	logic [31:0]   mop_a, mop_b;
	logic [63:0]   mul_out;

	rrss_ram #(.WIDTH(32), .DEPTH(MAX_PRODUCERS)) u_active (
		.clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata));
	rrss_ram #(.WIDTH(32), .DEPTH(MAX_PRODUCERS)) u_sched (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));
	rrss_mod u_mod (.clk, .arst_n, .req(mreq), .rsp(mrsp));

	// one 32x32 partial product per cycle of k * C
	always_comb begin
		unique case (state_q)
			S_M1:    begin mop_a = k_q[63:32]; mop_b = SHUF_MUL[31:0];  end
			S_M2:    begin mop_a = k_q[31:0];  mop_b = SHUF_MUL[63:32]; end
			default: begin mop_a = k_q[31:0];  mop_b = SHUF_MUL[31:0];  end
		endcase
		mul_out = 64'(mop_a) * 64'(mop_b);
	end

	always_comb begin
		a_we    = (state_q == S_IDLE) && in_valid && !in_stall &&
			(in_data.action == ACT_APPEND) && (acount_q < MAXC);
		a_waddr = acount_q[AW-1:0];
		a_wdata = in_data.producer_id;
		a_raddr = i_q[AW-1:0];
		s_we    = (state_q == S_CPWR) || (state_q == S_WRI) || (state_q == S_WRJ);
		priority case (state_q)
			S_CPWR:  begin s_waddr = i_q[AW-1:0]; s_wdata = a_rdata; end
			S_WRI:   begin s_waddr = j_q[AW-1:0]; s_wdata = s_rdata; end
			default: begin s_waddr = i_q[AW-1:0]; s_wdata = ti_q; end
		endcase
		priority case (state_q)
			S_RDI, S_JMOD: s_raddr = j_q[AW-1:0];
			S_QRD, S_QWAIT, S_QOUT: s_raddr = j_q[AW-1:0];
			default: s_raddr = i_q[AW-1:0];
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			acount_q  <= '0;
			scount_q  <= '0;
			out_valid <= 1'b0;
			mreq      <= '0;
		end else begin
			mreq.start <= 1'b0;
			if (out_valid && !out_stall && state_q != S_EOUT && state_q != S_QOUT)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					item_q <= in_data;
					i_q    <= '0;
					unique case (action_t'(in_data.action))
						ACT_CLEAR:  acount_q <= '0;
						ACT_APPEND: if (acount_q < MAXC) acount_q <= acount_q + 7'd1;
						ACT_UPDATE: if (acount_q != '0) begin
							n_q          <= acount_q;
							mreq.start    <= 1'b1;
							mreq.dividend <= {32'd0, in_data.block_number};
							mreq.divisor  <= acount_q;
							state_q       <= S_BMOD;
						end
						ACT_QUERY: if (scount_q == '0) begin
							state_q <= S_QOUT;
						end else begin
							mreq.start    <= 1'b1;
							mreq.dividend <= in_data.absolute_slot +
								{32'd0, in_data.slot_offset};
							mreq.divisor  <= scount_q;
							state_q       <= S_QMOD;
						end
					endcase
				end
				S_BMOD: if (mrsp.done) state_q <= (mrsp.rem == '0) ? S_CPRD : S_IDLE;
				S_CPRD: state_q <= S_CPWR;
				S_CPWR: begin
					if (i_q + 7'd1 == n_q) begin
						i_q      <= '0;
						scount_q <= n_q;
						state_q  <= S_SEED;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= S_CPRD;
					end
				end
				S_SEED: begin
					// C * i as shift-free running sum kept in p_q
					k_q     <= {item_q.block_time, 32'd0} + p_q;
					state_q <= S_XS;
				end
				S_XS: begin
					k_q <= (((k_q ^ (k_q >> 12)) ^ ((k_q ^ (k_q >> 12)) << 25)) ^
						(((k_q ^ (k_q >> 12)) ^ ((k_q ^ (k_q >> 12)) << 25)) >> 27));
					state_q <= S_M0;
				end
				S_M0: begin ti_q <= 32'd0; j_q <= '0;
					state_q <= S_M1;
					// product gathered in the spent slot field
					p_q <= p_q + SHUF_MUL;
					item_q.absolute_slot <= mul_out;
				end
				S_M1: begin
					item_q.absolute_slot[63:32] <= item_q.absolute_slot[63:32] +
						mul_out[31:0];
					state_q <= S_M2;
				end
				S_M2: begin
					item_q.absolute_slot[63:32] <= item_q.absolute_slot[63:32] +
						mul_out[31:0];
					state_q <= S_M3;
				end
				S_M3: begin
					mreq.start    <= 1'b1;
					mreq.dividend <= item_q.absolute_slot;
					mreq.divisor  <= n_q - i_q;
					state_q       <= S_JMOD;
				end
				S_JMOD: if (mrsp.done) begin
					j_q     <= 6'(i_q + mrsp.rem);
					state_q <= S_RDI;
				end
				S_RDI: state_q <= S_RDJ;    // entry j read under way
				S_RDJ: begin
					ti_q    <= s_rdata;     // entry j, i read under way
					state_q <= S_WRI;
				end
				S_WRI: state_q <= S_WRJ;     // entry i written to j
				S_WRJ: begin
					if (i_q + 7'd1 == n_q) begin
						i_q     <= '0;
						state_q <= S_ERD;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= S_SEED;
					end
				end
				S_ERD: state_q <= S_EWAIT;
				S_EWAIT: state_q <= S_EOUT;
				S_EOUT: if (!out_valid || !out_stall) begin
					out_data  <= '{1'b0, s_rdata, i_q[5:0], (i_q + 7'd1 == n_q), 1'b0};
					out_valid <= 1'b1;
					if (i_q + 7'd1 == n_q) begin
						state_q <= S_IDLE;
						p_q     <= '0;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= S_ERD;
					end
				end
				S_QMOD: if (mrsp.done) begin
					j_q     <= mrsp.rem[5:0];
					state_q <= S_QRD;
				end
				S_QRD: state_q <= S_QWAIT;
				S_QWAIT: state_q <= S_QOUT;
				S_QOUT: if (!out_valid || !out_stall) begin
					if (scount_q == '0) out_data <= '{1'b1, 32'd0, 6'd0, 1'b1, 1'b1};
					else out_data <= '{1'b1, s_rdata, j_q, 1'b1, 1'b0};
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_IDLE && in_valid && !in_stall) p_q <= '0;
		end
	end
endmodule
`default_nettype wire
